>>> rtl/core/per_channel_dead_time_filter_top_assert.svh
// ----------------------------------------------------------------------------
// per_channel_dead_time_filter_top_assert
// Assertion macros for the dead-time filter; ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef PER_CHANNEL_DEAD_TIME_FILTER_TOP_ASSERT_SVH
`define PER_CHANNEL_DEAD_TIME_FILTER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// checked only while out of reset
`define PCDTF_ASSERT_RUN(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
// checked on every edge, reset included
`define PCDTF_ASSERT_ALL(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define PCDTF_ASSERT_RUN(lbl, clk_s, rstn_s, prop, msg)
`define PCDTF_ASSERT_ALL(lbl, clk_s, prop, msg)
`endif

`endif

>>> rtl/core/pcdtf_pkg.sv
// ----------------------------------------------------------------------------
// pcdtf_pkg
// Shared types and field widths of the per-channel dead-time filter.
// ----------------------------------------------------------------------------
package pcdtf_pkg;

  localparam int CHAN_W     = 8;
  localparam int HIT_TIME_W = 48;
  localparam int DEAD_W     = 32;
  localparam int TDATA_W    = 56;
  localparam int CFG_ADDR_W = 1;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEAD_TIME   = 1'b0,
    REG_PARALYZABLE = 1'b1
  } cfg_reg_t;

  // decision of the update stage for one hit
  typedef struct packed {
    logic take;
    logic wr;
  } upd_ctl_t;

endpackage

>>> rtl/core/pcdtf_store.sv
// ----------------------------------------------------------------------------
// pcdtf_store
// Per-channel dead-interval end memory with valid flags and write bypass.
// ----------------------------------------------------------------------------
module pcdtf_store #(
  parameter int SLOTS   = 256,
  parameter int SLOT_W  = 8,
  parameter int TIME_W  = 48
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_slot,
  input  logic              wr_en,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [TIME_W-1:0] wr_end,
  output logic [TIME_W-1:0] rd_end,
  output logic              rd_vld
);
  import pcdtf_pkg::*;

  logic [TIME_W-1:0] mem [SLOTS];
  logic [TIME_W-1:0] mem_q_r;
  logic [SLOTS-1:0]  valid_r;
  logic [SLOT_W-1:0] rd_slot_r;
  logic              byp_r;
  logic [TIME_W-1:0] byp_end_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_end;
    end
    if (rd_en) begin
      mem_q_r   <= mem[rd_slot];
      rd_slot_r <= rd_slot;
      byp_end_r <= wr_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      byp_r   <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_slot] <= 1'b1;
      end
      // read and write of the same entry at one edge: memory returns old data
      if (rd_en) begin
        byp_r <= wr_en && (wr_slot == rd_slot);
      end
    end
  end

  assign rd_end = byp_r ? byp_end_r : mem_q_r;
  assign rd_vld = valid_r[rd_slot_r];

endmodule

>>> rtl/core/pcdtf_update.sv
// ----------------------------------------------------------------------------
// pcdtf_update
// Accept decision and saturating new end of the dead interval for one hit.
// ----------------------------------------------------------------------------
module pcdtf_update #(
  parameter int TIME_W = 48
) (
  input  logic [TIME_W-1:0]            hit_t,
  input  logic [TIME_W-1:0]            end_t,
  input  logic                         end_vld,
  input  logic [pcdtf_pkg::DEAD_W-1:0] dead_len,
  input  logic                         paralyzable,
  output logic [TIME_W-1:0]            new_end,
  output pcdtf_pkg::upd_ctl_t          ctl
);
  import pcdtf_pkg::*;

  localparam int SUM_W = ((TIME_W > DEAD_W) ? TIME_W : DEAD_W) + 1;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] max_ext;

  always_comb begin
    sum      = SUM_W'(hit_t) + SUM_W'(dead_len);
    max_ext  = SUM_W'({TIME_W{1'b1}});
    new_end  = (sum > max_ext) ? {TIME_W{1'b1}} : TIME_W'(sum);
    ctl.take = !end_vld || (hit_t > end_t);
    ctl.wr   = ctl.take || paralyzable;
  end

endmodule

>>> rtl/core/per_channel_dead_time_filter_top.sv
// ----------------------------------------------------------------------------
// per_channel_dead_time_filter_top
// Per-channel paralyzable / non-paralyzable dead-time filter for hit streams.
// ----------------------------------------------------------------------------
// Hits enter on the in_ stream (channel, time in ps); every hit leaves on the
// out_ stream with its channel and time and an accept flag in out_tuser.
// Registers are written on the cfg_ port while no hit is in flight:
// index 0 dead time in ps, index 1 paralyzable mode.
// Each hit is a read-compare-write of its channel's entry: the memory is read
// when the beat is taken, the compare stage compares and writes the new end
// when it advances, and the result lands in the output register. One hit per
// cycle is sustained while out_tready stays high, set by the single read port
// and single write port of the end-time memory. A hit on the same channel as
// the one just before it takes the written value from a bypass.
// Reset clears the per-channel valid flags at once (flip-flops, no sweep) and
// the registers to zero. When out_tready is low the output register and the
// compare stage hold, and in_tready drops once both are full.
// ----------------------------------------------------------------------------
`include "per_channel_dead_time_filter_top_assert.svh"

module per_channel_dead_time_filter_top #(
  parameter int CHANNEL_COUNT = 256,
  parameter int TIME_WIDTH    = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] channel, [55:8] hit_time
  input  logic [pcdtf_pkg::TDATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] out_channel, [55:8] out_time
  output logic [pcdtf_pkg::TDATA_W-1:0]    out_tdata,
  // [0] accepted
  output logic                             out_tuser,
  input  logic                             cfg_we,
  input  logic [pcdtf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pcdtf_pkg::DEAD_W-1:0]     cfg_wdata
);
  import pcdtf_pkg::*;

  localparam int SLOTS  = (CHANNEL_COUNT < 256) ? CHANNEL_COUNT : 256;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [DEAD_W-1:0]     dead_r;
  logic                  para_r;

  logic                  s1_valid_r;
  logic [CHAN_W-1:0]     s1_chan_r;
  logic [TIME_WIDTH-1:0] s1_time_r;
  logic [SLOT_W-1:0]     s1_slot_r;

  logic                  out_valid_r;
  logic [TDATA_W-1:0]    out_data_r;
  logic                  out_user_r;

  logic                  in_acc;
  logic                  s1_adv;
  logic [CHAN_W-1:0]     in_chan;
  logic [SLOT_W-1:0]     in_slot;
  logic [TIME_WIDTH-1:0] rd_end;
  logic                  rd_vld;
  logic [TIME_WIDTH-1:0] new_end;
  upd_ctl_t              ctl;
  logic                  wr_en;

  assign in_chan   = in_tdata[CHAN_W-1:0];
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_en     = s1_adv && ctl.wr;

  // channel to store entry: reduce modulo the channel count
  generate
    if (CHANNEL_COUNT >= 256) begin : g_direct
      assign in_slot = SLOT_W'(in_chan);
    end else begin : g_reduce
      logic [15:0] rem;
      always_comb begin
        rem = 16'(in_chan);
        for (int k = 7; k >= 0; k--) begin
          if (rem >= 16'(CHANNEL_COUNT << k)) begin
            rem = rem - 16'(CHANNEL_COUNT << k);
          end
        end
        in_slot = SLOT_W'(rem);
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_r <= '0;
      para_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_DEAD_TIME:   dead_r <= cfg_wdata;
        REG_PARALYZABLE: para_r <= cfg_wdata[0];
      endcase
    end
  end

  pcdtf_store #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W),
    .TIME_W (TIME_WIDTH)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_slot (in_slot),
    .wr_en   (wr_en),
    .wr_slot (s1_slot_r),
    .wr_end  (new_end),
    .rd_end  (rd_end),
    .rd_vld  (rd_vld)
  );

  pcdtf_update #(
    .TIME_W (TIME_WIDTH)
  ) u_update (
    .hit_t       (s1_time_r),
    .end_t       (rd_end),
    .end_vld     (rd_vld),
    .dead_len    (dead_r),
    .paralyzable (para_r),
    .new_end     (new_end),
    .ctl         (ctl)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_chan_r <= in_chan;
      s1_time_r <= TIME_WIDTH'(in_tdata[TDATA_W-1:CHAN_W]);
      s1_slot_r <= in_slot;
    end
    if (s1_adv) begin
      out_data_r <= {HIT_TIME_W'(s1_time_r), s1_chan_r};
      out_user_r <= ctl.take;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  `PCDTF_ASSERT_RUN(a_end_not_before_hit, clk, rst_n, wr_en |-> (new_end >= s1_time_r), "new dead end lies before hit time")
  `PCDTF_ASSERT_ALL(a_out_empty_after_reset, clk, !rst_n |=> !out_tvalid, "output valid right after reset")
  `PCDTF_ASSERT_RUN(a_stage_holds_on_stall, clk, rst_n, (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_time_r) && $stable(s1_slot_r)), "compare stage changed while stalled")

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of the per-channel dead-time filter.
// Drives hits, mostly forward in time, through the in_ stream, predicts the
// accept flag of each hit from a per-channel copy of the dead-window store,
// and checks every out_ beat in order.
// ----------------------------------------------------------------------------
module tb;
  import pcdtf_pkg::*;

  localparam logic [HIT_TIME_W-1:0] TIME_MAX = '1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int NUM_PHASES = 8;
  localparam int HITS_PER_PHASE = 145;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic                  accepted;
    logic [CHAN_W-1:0]     chan;
    logic [HIT_TIME_W-1:0] stamp;
  } hit_verdict_t;

  // per-channel dead-window predictor and in-order result check
  class hit_verdict_board;
    logic [HIT_TIME_W-1:0] window_end [256];
    bit                    window_set [256];
    logic [DEAD_W-1:0]     dead_ps;
    bit                    paralyzable;
    hit_verdict_t          verdict_q[$];
    int                    n_errors;
    int                    n_pass;
    int                    n_drop;

    function new();
      foreach (window_set[i]) begin
        window_set[i] = 1'b0;
        window_end[i] = '0;
      end
      dead_ps = '0;
      paralyzable = 1'b0;
      n_errors = 0;
      n_pass = 0;
      n_drop = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [DEAD_W-1:0] value);
      case (idx)
        REG_DEAD_TIME:   dead_ps = value;
        REG_PARALYZABLE: paralyzable = value[0];
        default: ;
      endcase
    endfunction

    // end of the dead window, saturating at the largest time
    function logic [HIT_TIME_W-1:0] closing_time(logic [HIT_TIME_W-1:0] t);
      logic [HIT_TIME_W-1:0] room;
      room = TIME_MAX - t;
      if ({16'b0, dead_ps} > room) return TIME_MAX;
      return t + {16'b0, dead_ps};
    endfunction

    function void predict_verdict(logic [CHAN_W-1:0] ch, logic [HIT_TIME_W-1:0] t);
      hit_verdict_t v;
      logic take;
      take = !window_set[ch] || (t > window_end[ch]);
      if (take || paralyzable) begin
        window_end[ch] = closing_time(t);
        window_set[ch] = 1'b1;
      end
      v.accepted = take;
      v.chan = ch;
      v.stamp = t;
      verdict_q.push_back(v);
      if (take) n_pass++;
      else n_drop++;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      n_errors++;
    endtask

    task check_verdict(logic [TDATA_W-1:0] data, logic user);
      hit_verdict_t v;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat ch=%0d t=%0d", data[7:0], data[55:8]));
        return;
      end
      v = verdict_q.pop_front();
      if (user !== v.accepted)
        report_mismatch($sformatf("accepted %0b, want %0b (ch=%0d t=%0d)",
                                  user, v.accepted, v.chan, v.stamp));
      if (data[CHAN_W-1:0] !== v.chan)
        report_mismatch($sformatf("channel %0d, want %0d", data[CHAN_W-1:0], v.chan));
      if (data[CHAN_W +: HIT_TIME_W] !== v.stamp)
        report_mismatch($sformatf("time %0d, want %0d", data[CHAN_W +: HIT_TIME_W], v.stamp));
    endtask

    function int pending();
      return verdict_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [TDATA_W-1:0]    out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [DEAD_W-1:0]     cfg_wdata;

  hit_verdict_board board = new();
  bit src_idle;
  bit snk_idle;
  // hold-off requests from the sender and the ones the receiver has served
  int hold_asked = 0;
  int hold_given = 0;
  int cycles = 0;
  int n_settings;

  per_channel_dead_time_filter_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", board.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic push_hit(input logic [CHAN_W-1:0] ch, input logic [HIT_TIME_W-1:0] t);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {t, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.predict_verdict(ch, t);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // block is idle here; the extra cycles cover the two-stage pipe
  task automatic write_reg(input cfg_reg_t idx, input logic [DEAD_W-1:0] value);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_reg(idx, value);
    n_settings++;
  endtask

  // next time of the stream: mostly forward steps scaled to the dead time,
  // sometimes a step back
  function automatic logic [HIT_TIME_W-1:0] next_stamp(logic [HIT_TIME_W-1:0] cur,
                                                      logic [DEAD_W-1:0] dead);
    logic [63:0] step;
    logic [63:0] sum;
    step = 64'd0;
    case ($urandom_range(0, 9))
      0, 1:    step = 64'd0;
      2, 3, 4: step = rand64() % ({32'b0, dead} / 2 + 1);
      5, 6:    step = rand64() % ({32'b0, dead} * 2 + 3);
      7:       step = {32'b0, dead};
      8:       step = {32'b0, dead} + 1;
      default: begin
        step = rand64() % ({32'b0, dead} + 2);
        return (step[47:0] > cur) ? '0 : cur - step[47:0];
      end
    endcase
    sum = {16'b0, cur} + step;
    if (sum > {16'b0, TIME_MAX}) return TIME_MAX;
    return sum[HIT_TIME_W-1:0];
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_asked != hold_given) begin
        hold_given = hold_asked;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = snk_idle ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      board.check_verdict(out_tdata, out_tuser);
    end
  end

  initial begin
    logic [DEAD_W-1:0]     dead_set [NUM_PHASES];
    logic [CHAN_W-1:0]     pool [4];
    logic [CHAN_W-1:0]     ch;
    logic [HIT_TIME_W-1:0] stamp;
    int                    pick;

    n_settings = 0;
    src_idle  = 1'b0;
    snk_idle  = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= REG_DEAD_TIME;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, equal times, zero dead time
    push_hit(8'd0, 48'd0);
    push_hit(8'd0, 48'd0);
    push_hit(8'd0, 48'd1);
    push_hit(8'hFF, 48'd0);
    wait_drained();
    // saturated window end, hit at the largest time
    write_reg(REG_DEAD_TIME, 32'hFFFF_FFFF);
    push_hit(8'hAA, TIME_MAX - 48'd5);
    push_hit(8'hAA, TIME_MAX);
    push_hit(8'h55, TIME_MAX);
    push_hit(8'h55, TIME_MAX);
    wait_drained();
    // paralyzable extension, back-to-back same channel, out-of-order time
    write_reg(REG_DEAD_TIME, 32'd100);
    write_reg(REG_PARALYZABLE, 32'd1);
    push_hit(8'd3, 48'd1000);
    push_hit(8'd3, 48'd1100);
    push_hit(8'd3, 48'd1150);
    push_hit(8'd3, 48'd1251);
    push_hit(8'd3, 48'd500);
    push_hit(8'd3, 48'd601);
    wait_drained();
    write_reg(REG_PARALYZABLE, 32'd0);
    push_hit(8'd3, 48'd700);
    push_hit(8'd3, 48'd701);
    push_hit(8'd3, 48'd702);
    push_hit(8'h80, 48'h8000_0000_0000);
    push_hit(8'h7F, 48'h7FFF_FFFF_FFFF);
    wait_drained();

    dead_set[0] = 32'd0;
    dead_set[1] = 32'd1;
    dead_set[2] = 32'd37;
    dead_set[3] = 32'd1000;
    dead_set[4] = 32'hFFFF_FFFF;
    dead_set[5] = $urandom;
    dead_set[6] = 32'h8000_0000;
    dead_set[7] = $urandom_range(2, 500);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_DEAD_TIME, dead_set[ph]);
      write_reg(REG_PARALYZABLE, ph % 2);
      src_idle = (ph != 0) && (ph != 3) && $urandom_range(0, 3) != 0;
      snk_idle = (ph != 0) && $urandom_range(0, 3) != 0;
      foreach (pool[i]) pool[i] = CHAN_W'($urandom);
      stamp = (ph == 4 || ph == 7) ? TIME_MAX - HIT_TIME_W'($urandom_range(0, 100000))
                                   : HIT_TIME_W'(rand64());
      ch = pool[0];
      for (int n = 0; n < HITS_PER_PHASE; n++) begin
        if (ph == 3 && n == 10) hold_asked++;
        if (ph == 5 && n == 70) wait_drained();
        pick = $urandom_range(0, 19);
        if (pick < 14) ch = pool[$urandom_range(0, 3)];
        else if (pick < 17) ch = CHAN_W'($urandom);
        stamp = next_stamp(stamp, dead_set[ph]);
        // a saturated stream restarts somewhere else now and then
        if (stamp == TIME_MAX && $urandom_range(0, 3) == 0) stamp = HIT_TIME_W'(rand64());
        push_hit(ch, stamp);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d hits (%0d passed, %0d dropped) under %0d register writes,",
             board.n_pass + board.n_drop, board.n_pass, board.n_drop, n_settings);
    $display("both modes, dead times from zero to full scale, stalls on both sides");
    if (board.n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
